>>> rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Every check samples on the rising
// edge of clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/gpt_pkg.sv
`default_nettype none

package gpt_pkg;

  localparam int NUM_CPUS_DEF    = 8;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int REQ_W    = 3;
  localparam int CPU_ID_W = 3;
  localparam int GEN_W    = 64;
  localparam int REL_W    = 16;
  localparam int PEND_W   = 8;

  // Event kinds; codes 5 to 7 mean nothing and leave the state alone.
  typedef enum logic [REQ_W-1:0] {
    REQ_QUIET    = 3'd0,
    REQ_ENABLE   = 3'd1,
    REQ_DISABLE  = 3'd2,
    REQ_REGISTER = 3'd3,
    REQ_DRAIN    = 3'd4
  } req_kind_t;

  typedef struct packed {
    logic [REQ_W-1:0]    req_type;
    logic [CPU_ID_W-1:0] cpu_id;
  } in_word_t;

  typedef struct packed {
    logic              queue_task;
    logic [REL_W-1:0]  released_count;
    logic [GEN_W-1:0]  global_generation;
    logic [PEND_W-1:0] pending_mask;
    logic              overflow;
  } out_word_t;

  // Generation bookkeeping produced by one quiescent report.
  typedef struct packed {
    logic [GEN_W-1:0] gen;
    logic [GEN_W-1:0] max_gen;
    logic [GEN_W-1:0] target;
    logic             retire;
  } gen_step_t;

endpackage

`default_nettype wire

>>> rtl/gpt_gen_step.sv
`default_nettype none

// Generation arithmetic of one quiescent report. All candidate generations
// are formed in parallel from the current value and then selected.
module gpt_gen_step #(
  parameter int NUM_CPUS = gpt_pkg::NUM_CPUS_DEF
) (
  input  wire logic [gpt_pkg::GEN_W-1:0] generation,
  input  wire logic [gpt_pkg::GEN_W-1:0] max_generation,
  input  wire logic [gpt_pkg::GEN_W-1:0] target,
  input  wire logic [NUM_CPUS-1:0]       waiting_mask,
  input  wire logic [NUM_CPUS-1:0]       enabled_nxt,
  input  wire logic [NUM_CPUS-1:0]       cpu_bit,
  input  wire logic                      cur_nz,
  input  wire logic                      next_nz,
  output logic      [NUM_CPUS-1:0]       waiting_nxt,
  output gpt_pkg::gen_step_t             step
);

  logic [gpt_pkg::GEN_W-1:0] cand [6];
  logic [NUM_CPUS-1:0]       w_mid;
  logic [gpt_pkg::GEN_W-1:0] max_mid;
  logic [2:0]                ofs;
  logic                      period_end;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      cand[k] = generation + gpt_pkg::GEN_W'(k);
    end

    w_mid      = waiting_mask & ~cpu_bit;
    period_end = (|(waiting_mask & cpu_bit)) && (w_mid == '0);
    max_mid    = max_generation;
    ofs        = 3'd0;

    // Last CPU reported: the period ends, and a new one opens if requested.
    if (period_end) begin
      if (cand[1] <= max_generation) begin
        w_mid   = enabled_nxt;
        max_mid = cand[2];
        ofs     = (enabled_nxt == '0) ? 3'd3 : 3'd2;
      end else begin
        ofs = 3'd1;
      end
    end

    step.gen     = cand[ofs];
    step.max_gen = max_mid;
    step.target  = target;
    step.retire  = cur_nz && (cand[ofs] > target);
    waiting_nxt  = w_mid;

    // Waiting callbacks become current and ask for the following period.
    if (next_nz) begin
      step.target = cand[ofs + 3'd1];
      if (w_mid != '0) begin
        step.max_gen = cand[ofs + 3'd2];
      end else begin
        waiting_nxt  = enabled_nxt;
        step.max_gen = cand[ofs + 3'd1];
        step.gen     = (enabled_nxt == '0) ? cand[ofs + 3'd2] : cand[ofs + 3'd1];
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/grace_period_tracker.sv
// An accepted word passes the input register, then the output register. One
// word per cycle is taken while the output is not stalled; an input register,
// one pass of update logic on the per-CPU registers and an output register
// keep both sides decoupled. Reset (rst_n low at a clock edge) empties both
// stages and clears all masks, generations and per-CPU counts to zero.
`default_nettype none

`include "assert_macros.svh"

module grace_period_tracker #(
  parameter int NUM_CPUS    = gpt_pkg::NUM_CPUS_DEF,
  parameter int COUNT_WIDTH = gpt_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire gpt_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output gpt_pkg::out_word_t      out_data
);

  localparam int CIW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int RW  = (COUNT_WIDTH > gpt_pkg::REL_W) ? COUNT_WIDTH : gpt_pkg::REL_W;
  localparam int GW  = gpt_pkg::GEN_W;

  // Pipeline stages. The input stage holds the word being worked on; the
  // state registers are written at the same edge that moves it to the output
  // register, so the word behind it always sees fully updated state.
  logic               s1_valid_r;
  gpt_pkg::in_word_t  s1_data_r;
  logic               out_valid_r;
  gpt_pkg::out_word_t out_data_r;
  gpt_pkg::out_word_t out_data_nxt;
  logic               adv;

  // Global state.
  logic [NUM_CPUS-1:0] enabled_mask_r, enabled_mask_nxt;
  logic [NUM_CPUS-1:0] waiting_mask_r, waiting_mask_nxt;
  logic [GW-1:0]       generation_r, generation_nxt;
  logic [GW-1:0]       max_generation_r, max_generation_nxt;

  // Per-CPU state, one register per entry, written only at the addressed CPU.
  logic [GW-1:0]          target_r      [NUM_CPUS];
  logic [COUNT_WIDTH-1:0] next_count_r  [NUM_CPUS];
  logic [COUNT_WIDTH-1:0] cur_count_r   [NUM_CPUS];
  logic [COUNT_WIDTH-1:0] ready_count_r [NUM_CPUS];
  logic [NUM_CPUS-1:0]    drain_queued_r;

  logic [GW-1:0]          target_nxt;
  logic [COUNT_WIDTH-1:0] next_nxt, cur_nxt, ready_nxt;
  logic                   dq_nxt;
  logic                   cpu_wr;

  // Decode of the word in the input stage.
  logic [CIW-1:0]      idx;
  logic                hit;
  logic [NUM_CPUS-1:0] cpu_bit;
  logic                is_quiet;

  logic [GW-1:0]          sel_target;
  logic [COUNT_WIDTH-1:0] sel_next, sel_cur, sel_ready;
  logic                   sel_dq;

  logic [NUM_CPUS-1:0] waiting_step;
  gpt_pkg::gen_step_t  step;

  logic [COUNT_WIDTH:0]   sum_ready, sum_cur, sum_next;
  logic [COUNT_WIDTH-1:0] cur_mid;
  logic [COUNT_WIDTH-1:0] released;
  logic [RW-1:0]          released_ext;
  logic                   queued, lost;

  assign adv       = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || adv;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign idx     = CIW'(s1_data_r.cpu_id);
  assign hit     = int'(s1_data_r.cpu_id) < NUM_CPUS;
  assign cpu_bit = hit ? (NUM_CPUS'(1) << idx) : '0;

  always_comb begin
    sel_target = '0;
    sel_next   = '0;
    sel_cur    = '0;
    sel_ready  = '0;
    sel_dq     = 1'b0;
    if (hit) begin
      sel_target = target_r[idx];
      sel_next   = next_count_r[idx];
      sel_cur    = cur_count_r[idx];
      sel_ready  = ready_count_r[idx];
      sel_dq     = drain_queued_r[idx];
    end
  end

  // Enable and disable take effect before the quiescent report they carry.
  always_comb begin
    enabled_mask_nxt = enabled_mask_r;
    is_quiet         = 1'b0;
    if (hit) begin
      unique case (s1_data_r.req_type)
        gpt_pkg::REQ_QUIET: begin
          is_quiet = 1'b1;
        end
        gpt_pkg::REQ_ENABLE: begin
          is_quiet         = 1'b1;
          enabled_mask_nxt = enabled_mask_r | cpu_bit;
        end
        gpt_pkg::REQ_DISABLE: begin
          is_quiet         = 1'b1;
          enabled_mask_nxt = enabled_mask_r & ~cpu_bit;
        end
        default: begin
          is_quiet = 1'b0;
        end
      endcase
    end
  end

  gpt_gen_step #(
    .NUM_CPUS (NUM_CPUS)
  ) u_gen_step (
    .generation     (generation_r),
    .max_generation (max_generation_r),
    .target         (sel_target),
    .waiting_mask   (waiting_mask_r),
    .enabled_nxt    (enabled_mask_nxt),
    .cpu_bit        (cpu_bit),
    .cur_nz         (sel_cur != '0),
    .next_nz        (sel_next != '0),
    .waiting_nxt    (waiting_step),
    .step           (step)
  );

  // Count arithmetic. Each sum carries one extra bit; a set top bit means the
  // count saturates and the callbacks beyond the maximum are dropped.
  assign cur_mid   = step.retire ? '0 : sel_cur;
  assign sum_ready = (COUNT_WIDTH + 1)'(sel_ready) + (COUNT_WIDTH + 1)'(sel_cur);
  assign sum_cur   = (COUNT_WIDTH + 1)'(cur_mid) + (COUNT_WIDTH + 1)'(sel_next);
  assign sum_next  = (COUNT_WIDTH + 1)'(sel_next) + (COUNT_WIDTH + 1)'(1);

  always_comb begin
    waiting_mask_nxt   = waiting_mask_r;
    generation_nxt     = generation_r;
    max_generation_nxt = max_generation_r;
    target_nxt         = sel_target;
    next_nxt           = sel_next;
    cur_nxt            = sel_cur;
    ready_nxt          = sel_ready;
    dq_nxt             = sel_dq;
    cpu_wr             = 1'b0;
    queued             = 1'b0;
    lost               = 1'b0;
    released           = '0;

    if (is_quiet) begin
      cpu_wr             = 1'b1;
      waiting_mask_nxt   = waiting_step;
      generation_nxt     = step.gen;
      max_generation_nxt = step.max_gen;
      // Current batch whose period has passed becomes ready for draining.
      if (step.retire) begin
        released  = sel_cur;
        ready_nxt = sum_ready[COUNT_WIDTH] ? '1 : sum_ready[COUNT_WIDTH-1:0];
        lost      = sum_ready[COUNT_WIDTH];
        cur_nxt   = '0;
        if (!sel_dq) begin
          dq_nxt = 1'b1;
          queued = 1'b1;
        end
      end
      // Waiting callbacks join the current batch under a new target.
      if (sel_next != '0) begin
        cur_nxt    = sum_cur[COUNT_WIDTH] ? '1 : sum_cur[COUNT_WIDTH-1:0];
        lost       = lost || sum_cur[COUNT_WIDTH];
        next_nxt   = '0;
        target_nxt = step.target;
      end
    end else if (hit && (s1_data_r.req_type == gpt_pkg::REQ_REGISTER)) begin
      cpu_wr   = 1'b1;
      next_nxt = sum_next[COUNT_WIDTH] ? '1 : sum_next[COUNT_WIDTH-1:0];
      lost     = sum_next[COUNT_WIDTH];
    end else if (hit && (s1_data_r.req_type == gpt_pkg::REQ_DRAIN)) begin
      cpu_wr    = 1'b1;
      released  = sel_ready;
      ready_nxt = '0;
      dq_nxt    = 1'b0;
    end
  end

  // The reported count is clamped to the width of the output field.
  assign released_ext = RW'(released);

  always_comb begin
    out_data_nxt.queue_task        = queued;
    out_data_nxt.released_count    = (released_ext > RW'(16'hFFFF)) ?
                                     16'hFFFF : released_ext[gpt_pkg::REL_W-1:0];
    out_data_nxt.global_generation = generation_nxt;
    out_data_nxt.pending_mask      = gpt_pkg::PEND_W'(waiting_mask_nxt);
    out_data_nxt.overflow          = lost;
  end

  // Pipeline control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Tracker state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_mask_r   <= '0;
      waiting_mask_r   <= '0;
      generation_r     <= '0;
      max_generation_r <= '0;
      drain_queued_r   <= '0;
      for (int i = 0; i < NUM_CPUS; i++) begin
        target_r[i]      <= '0;
        next_count_r[i]  <= '0;
        cur_count_r[i]   <= '0;
        ready_count_r[i] <= '0;
      end
    end else if (adv) begin
      enabled_mask_r   <= enabled_mask_nxt;
      waiting_mask_r   <= waiting_mask_nxt;
      generation_r     <= generation_nxt;
      max_generation_r <= max_generation_nxt;
      if (cpu_wr) begin
        target_r[idx]       <= target_nxt;
        next_count_r[idx]   <= next_nxt;
        cur_count_r[idx]    <= cur_nxt;
        ready_count_r[idx]  <= ready_nxt;
        drain_queued_r[idx] <= dq_nxt;
      end
    end
  end

  // A CPU can only owe a quiescent state while it is enabled.
  `ASSERT_NEVER(a_waiting_in_enabled, (waiting_mask_r & ~enabled_mask_r) != '0, "waiting CPU not enabled")
  // State moves only together with a word leaving the input stage.
  `ASSERT_CLK(a_gen_only_on_adv, !adv |=> $stable(generation_r) && $stable(waiting_mask_r), "state changed without a word")
  // A word held by a full output stage is kept, not dropped.
  `ASSERT_CLK(a_s1_held, s1_valid_r && out_valid_r && !out_ready |=> s1_valid_r, "input stage word lost")

endmodule

`default_nettype wire
